// ----- rtl/bbse_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bbse_pkg
// Shared constants and helpers for the bicubic Bezier surface evaluator.
// ----------------------------------------------------------------------------
package bbse_pkg;

    localparam int MAX_POINTS_DEF  = 1024;
    localparam int MAX_PATCHES_DEF = 8;
    localparam int COORD_BITS_DEF  = 32;

    localparam int PW      = 17;           // Q1.16 weight width, 65536 is 1.0
    localparam logic [PW-1:0] ONE_Q16 = 17'h10000;

    // operation codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_EVAL  = 1'b1;

    // register indexes
    localparam logic [1:0] REG_PATCHES_ACROSS = 2'd0;
    localparam logic [1:0] REG_PATCHES_DOWN   = 2'd1;
    localparam logic [1:0] REG_WRAP_ACROSS    = 2'd2;
    localparam logic [1:0] REG_WRAP_DOWN      = 2'd3;

    // one de casteljau step pair: a*w + b*t rounded to q1.16
    function automatic logic [PW-1:0] lerp_q16(input logic [PW-1:0] a,
                                               input logic [PW-1:0] b,
                                               input logic [PW-1:0] w,
                                               input logic [PW-1:0] t);
        logic [35:0] s;
        begin
            s = {19'd0, a} * {19'd0, w} + {19'd0, b} * {19'd0, t} + 36'd32768;
            lerp_q16 = s[32:16];
        end
    endfunction

endpackage
`default_nettype wire

// ----- rtl/bicubic_bezier_surface_eval.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bicubic_bezier_surface_eval
// Bicubic Bezier patch evaluator over a grid of stored control points.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on start while busy is low. func selects a control point
//   write (stored in the point memory, no result) or a surface evaluation.
//   An evaluation locates the patch, builds the u and v weights, then
//   walks the 16 control points of the patch through one memory read
//   port, one point per cycle, multiplying each by its u weight and
//   folding each finished row by its v weight. The result shows on
//   surf_x/y/z with done high for one cycle; busy drops in that same
//   cycle, so one evaluation runs at a time and the next item is taken
//   at the edge ending the done cycle. Writes can follow back to back.
//   Configuration uses cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready
//   is always high. Reset restores the configuration registers and clears
//   control; the point memory holds no reset value. The receiver cannot
//   stall: done is a single-cycle strobe.
// ----------------------------------------------------------------------------
module bicubic_bezier_surface_eval
#(
    parameter int MAX_POINTS  = bbse_pkg::MAX_POINTS_DEF,
    parameter int MAX_PATCHES = bbse_pkg::MAX_PATCHES_DEF,
    parameter int COORD_BITS  = bbse_pkg::COORD_BITS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic                   func,
    input  wire logic [9:0]             point_slot,
    input  wire logic [COORD_BITS-1:0]  coord_x,
    input  wire logic [COORD_BITS-1:0]  coord_y,
    input  wire logic [COORD_BITS-1:0]  coord_z,
    input  wire logic [16:0]            param_u,
    input  wire logic [16:0]            param_v,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [1:0]             cfg_index,
    input  wire logic [3:0]             cfg_data,
    output logic                        done,
    output logic [COORD_BITS-1:0]       surf_x,
    output logic [COORD_BITS-1:0]       surf_y,
    output logic [COORD_BITS-1:0]       surf_z
);

    localparam int CW   = (COORD_BITS < 32) ? COORD_BITS : 32;
    localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int IW   = 12;                 // grid index width, 25*25 max
    localparam int PRW  = CW + 20;            // row sum width
    localparam int ACW  = CW + 22;            // v accumulator width
    localparam logic [IW:0]   MAXP_I = (IW+1)'(MAX_POINTS);
    localparam logic [4:0]    MAXPA  = 5'(MAX_PATCHES);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WGT  = 3'd1;
    localparam logic [2:0] S_RUN  = 3'd2;
    localparam logic [2:0] S_ROW  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    typedef logic signed [CW-1:0] crd_t;

    // configuration registers
    logic [3:0] pa_reg, pd_reg;
    logic       wa_reg, wd_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pa_reg <= 4'd1;
            pd_reg <= 4'd1;
            wa_reg <= 1'b0;
            wd_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                bbse_pkg::REG_PATCHES_ACROSS: pa_reg <= cfg_data;
                bbse_pkg::REG_PATCHES_DOWN:   pd_reg <= cfg_data;
                bbse_pkg::REG_WRAP_ACROSS:    wa_reg <= cfg_data[0];
                bbse_pkg::REG_WRAP_DOWN:      wd_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // effective patch counts and axis point counts
    logic [3:0]    pu, pv;
    logic [IW-1:0] nu, nv;

    always_comb
    begin
        pu = (pa_reg == 4'd0) ? 4'd1 : (({1'b0, pa_reg} > MAXPA) ? MAXPA[3:0] : pa_reg);
        pv = (pd_reg == 4'd0) ? 4'd1 : (({1'b0, pd_reg} > MAXPA) ? MAXPA[3:0] : pd_reg);
        nu = IW'(pu) * IW'(3) + (wa_reg ? IW'(0) : IW'(1));
        nv = IW'(pv) * IW'(3) + (wd_reg ? IW'(0) : IW'(1));
    end

    // patch location on one axis
    function automatic logic [24:0] locate(input logic [16:0] p, input logic [3:0] n);
        logic [16:0] q;
        logic [20:0] s;
        logic [3:0]  k;
        logic [20:0] tt;
        begin
            q = (p > bbse_pkg::ONE_Q16) ? bbse_pkg::ONE_Q16 : p;
            s = 21'(q) * 21'(n);
            k = s[19:16];
            if (s[20] || (k >= n))
                k = n - 4'd1;
            tt = s - {1'b0, k, 16'd0};
            locate = {k, tt[16:0], 4'd0};
        end
    endfunction

    logic [24:0] lu, lv;
    assign lu = locate(param_u, pu);
    assign lv = locate(param_v, pv);

    // control point memories
    crd_t mem_x [MAX_POINTS];
    crd_t mem_y [MAX_POINTS];
    crd_t mem_z [MAX_POINTS];
    crd_t rd_x, rd_y, rd_z;
    logic [AW-1:0] rd_addr;

    logic accept;
    assign accept = start && !busy;

    always_ff @(posedge clk)
    begin
        if (accept && (func == bbse_pkg::FUNC_WRITE) && (32'(point_slot) < MAX_POINTS))
        begin
            mem_x[AW'(point_slot)] <= crd_t'(coord_x[CW-1:0]);
            mem_y[AW'(point_slot)] <= crd_t'(coord_y[CW-1:0]);
            mem_z[AW'(point_slot)] <= crd_t'(coord_z[CW-1:0]);
        end
        rd_x <= mem_x[rd_addr];
        rd_y <= mem_y[rd_addr];
        rd_z <= mem_z[rd_addr];
    end

    // weight units
    logic wgo, wdone_u, wdone_v;
    logic [16:0] wu0, wu1, wu2, wu3, wv0, wv1, wv2, wv3;

    bbse_weights u_wu (.clk(clk), .rst_n(rst_n), .go(wgo), .t(lu[20:4]),
        .done(wdone_u), .b0(wu0), .b1(wu1), .b2(wu2), .b3(wu3));
    bbse_weights u_wv (.clk(clk), .rst_n(rst_n), .go(wgo), .t(lv[20:4]),
        .done(wdone_v), .b0(wv0), .b1(wv1), .b2(wv2), .b3(wv3));

    // sequencer state
    logic [2:0]    st_reg, st_next;
    logic [3:0]    cnt_reg, cnt_next;      // read counter, row*4+col
    logic          vld_reg;                // read data valid
    logic [1:0]    vcol_reg;               // column of read data
    logic          vin_reg;                // read index in range
    logic [IW-1:0] col_reg, row_reg;
    logic          oob;

    assign wgo = accept && (func == bbse_pkg::FUNC_EVAL);

    // address generation with wrap
    logic [IW-1:0] c_idx, r_idx, g_idx;
    always_comb
    begin
        c_idx = col_reg + IW'(cnt_reg[1:0]);
        if (wa_reg && (c_idx >= nu))
            c_idx = c_idx - nu;
        r_idx = row_reg + IW'(cnt_reg[3:2]);
        if (wd_reg && (r_idx >= nv))
            r_idx = r_idx - nv;
        g_idx = IW'(r_idx * nu) + c_idx;
        oob = ({1'b0, g_idx} >= MAXP_I);
        rd_addr = oob ? '0 : AW'(g_idx);
    end

    logic rd_en;
    assign rd_en = (st_reg == S_RUN);

    always_comb
    begin
        st_next  = st_reg;
        cnt_next = cnt_reg;
        case (st_reg)
            S_IDLE:  if (wgo) st_next = S_WGT;
            S_WGT:   if (wdone_u) begin st_next = S_RUN; cnt_next = '0; end
            S_RUN:
            begin
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15) st_next = S_ROW;
            end
            S_ROW:   st_next = S_FIN;
            S_FIN:   st_next = S_OUT;
            S_OUT:   st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= S_IDLE;
            cnt_reg <= '0;
            vld_reg <= 1'b0;
        end
        else
        begin
            st_reg  <= st_next;
            cnt_reg <= cnt_next;
            vld_reg <= rd_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wgo)
        begin
            col_reg <= IW'(lu[24:21]) * IW'(3);
            row_reg <= IW'(lv[24:21]) * IW'(3);
        end
        vcol_reg <= cnt_reg[1:0];
        vin_reg  <= !oob;
    end

    // multiply stage: point times u weight
    logic [16:0] wsel;
    always_comb
    begin
        case (vcol_reg)
            2'd0:    wsel = wu0;
            2'd1:    wsel = wu1;
            2'd2:    wsel = wu2;
            default: wsel = wu3;
        endcase
    end

    logic signed [CW+17:0] px_reg, py_reg, pz_reg;
    logic                  pv_reg, plast_reg;
    logic [1:0]            prow_reg, vrow_reg;
    logic [1:0]            pcol_reg;

    always_ff @(posedge clk)
    begin
        px_reg <= (vin_reg ? (CW+18)'(rd_x) : '0) * $signed({1'b0, wsel});
        py_reg <= (vin_reg ? (CW+18)'(rd_y) : '0) * $signed({1'b0, wsel});
        pz_reg <= (vin_reg ? (CW+18)'(rd_z) : '0) * $signed({1'b0, wsel});
        pcol_reg <= vcol_reg;
        prow_reg <= vrow_reg;
    end

    always_ff @(posedge clk)
    begin
        vrow_reg <= cnt_reg[3:2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg    <= 1'b0;
            plast_reg <= 1'b0;
        end
        else
        begin
            pv_reg    <= vld_reg;
            plast_reg <= vld_reg && (vcol_reg == 2'd3);
        end
    end

    // row accumulation then v weighting
    logic signed [PRW-1:0] rx_reg, ry_reg, rz_reg;
    logic signed [PRW-1:0] sx, sy, sz;
    logic                  rdone_reg;
    logic [1:0]            rrow_reg;

    always_comb
    begin
        sx = ((pcol_reg == 2'd0) ? '0 : rx_reg) + PRW'(px_reg);
        sy = ((pcol_reg == 2'd0) ? '0 : ry_reg) + PRW'(py_reg);
        sz = ((pcol_reg == 2'd0) ? '0 : rz_reg) + PRW'(pz_reg);
    end

    always_ff @(posedge clk)
    begin
        if (pv_reg)
        begin
            rx_reg <= sx;
            ry_reg <= sy;
            rz_reg <= sz;
        end
        rrow_reg <= prow_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rdone_reg <= 1'b0;
        else
            rdone_reg <= plast_reg;
    end

    // round half up to q16.16 (floor of x + 2^15 then shift)
    function automatic logic signed [PRW-17:0] rnd(input logic signed [PRW-1:0] x);
        logic signed [PRW-1:0] y;
        begin
            y = x + PRW'(32768);
            rnd = y[PRW-1:16];
        end
    endfunction

    logic [16:0] vsel;
    always_comb
    begin
        case (rrow_reg)
            2'd0:    vsel = wv0;
            2'd1:    vsel = wv1;
            2'd2:    vsel = wv2;
            default: vsel = wv3;
        endcase
    end

    logic signed [ACW-1:0] qx_reg, qy_reg, qz_reg;
    logic signed [ACW-1:0] ax_reg, ay_reg, az_reg;
    logic                  qv_reg;
    logic [1:0]            qrow_reg;

    always_ff @(posedge clk)
    begin
        qx_reg <= ACW'(rnd(rx_reg)) * $signed({1'b0, vsel});
        qy_reg <= ACW'(rnd(ry_reg)) * $signed({1'b0, vsel});
        qz_reg <= ACW'(rnd(rz_reg)) * $signed({1'b0, vsel});
        qrow_reg <= rrow_reg;
        if (qv_reg)
        begin
            ax_reg <= ((qrow_reg == 2'd0) ? '0 : ax_reg) + qx_reg;
            ay_reg <= ((qrow_reg == 2'd0) ? '0 : ay_reg) + qy_reg;
            az_reg <= ((qrow_reg == 2'd0) ? '0 : az_reg) + qz_reg;
        end
    end

    logic qlast_reg, alast_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qv_reg    <= 1'b0;
            qlast_reg <= 1'b0;
            alast_reg <= 1'b0;
        end
        else
        begin
            qv_reg    <= rdone_reg;
            qlast_reg <= rdone_reg && (rrow_reg == 2'd3);
            alast_reg <= qlast_reg;
        end
    end

    // final rounding, saturation and output register
    function automatic logic [CW-1:0] sat(input logic signed [ACW-1:0] x);
        logic signed [ACW-1:0] y;
        logic signed [ACW-17:0] r;
        logic signed [ACW-17:0] hi, lo;
        begin
            y  = x + ACW'(32768);
            r  = y[ACW-1:16];
            hi = (ACW-16)'({1'b0, {(CW-1){1'b1}}});
            lo = -hi - (ACW-16)'(1);
            if (r > hi)      sat = hi[CW-1:0];
            else if (r < lo) sat = lo[CW-1:0];
            else             sat = r[CW-1:0];
        end
    endfunction

    logic done_reg;
    logic [CW-1:0] ox_reg, oy_reg, oz_reg;

    always_ff @(posedge clk)
    begin
        if (alast_reg)
        begin
            ox_reg <= sat(ax_reg);
            oy_reg <= sat(ay_reg);
            oz_reg <= sat(az_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= alast_reg;
    end

    // busy covers the whole evaluation pipeline
    logic pend_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= 1'b0;
        else if (wgo)
            pend_reg <= 1'b1;
        else if (alast_reg)
            pend_reg <= 1'b0;
    end

    assign busy   = pend_reg;
    assign done   = done_reg;
    assign surf_x = COORD_BITS'($signed(ox_reg));
    assign surf_y = COORD_BITS'($signed(oy_reg));
    assign surf_z = COORD_BITS'($signed(oz_reg));

    // checks
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("done while still busy");
    a_weights_same: assert property (@(posedge clk) disable iff (!rst_n)
        wdone_u == wdone_v) else $error("weight units out of step");
    a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_RUN) |-> busy) else $error("memory walk while idle");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done longer than one cycle");

endmodule
`default_nettype wire

// ----- rtl/bbse_weights.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bbse_weights
// Cubic Bernstein weights by de Casteljau recurrence, one level per cycle.
// ----------------------------------------------------------------------------
module bbse_weights
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      go,
    input  wire logic [bbse_pkg::PW-1:0]   t,
    output logic                           done,
    output logic [bbse_pkg::PW-1:0]        b0,
    output logic [bbse_pkg::PW-1:0]        b1,
    output logic [bbse_pkg::PW-1:0]        b2,
    output logic [bbse_pkg::PW-1:0]        b3
);

    logic [1:0]                 lvl_reg;
    logic [1:0]                 lvl_next;
    logic                       run_reg;
    logic                       run_next;
    logic [bbse_pkg::PW-1:0]    t_reg;
    logic [bbse_pkg::PW-1:0]    w;

    assign w = bbse_pkg::ONE_Q16 - t_reg;

    // level counter
    always_comb
    begin
        run_next = run_reg;
        lvl_next = lvl_reg;
        if (go)
        begin
            run_next = 1'b1;
            lvl_next = 2'd0;
        end
        else if (run_reg)
        begin
            lvl_next = lvl_reg + 2'd1;
            if (lvl_reg == 2'd2)
                run_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            lvl_reg <= 2'd0;
        end
        else
        begin
            run_reg <= run_next;
            lvl_reg <= lvl_next;
        end
    end

    assign done = run_reg && (lvl_reg == 2'd2);

    // weight registers, updated in place per level
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            t_reg <= t;
            b0 <= bbse_pkg::ONE_Q16;
            b1 <= '0;
            b2 <= '0;
            b3 <= '0;
        end
        else if (run_reg)
        begin
            b3 <= bbse_pkg::lerp_q16(b3, b2, w, t_reg);
            b2 <= bbse_pkg::lerp_q16(b2, b1, w, t_reg);
            b1 <= bbse_pkg::lerp_q16(b1, b0, w, t_reg);
            b0 <= bbse_pkg::lerp_q16(b0, '0, w, t_reg);
        end
    end

endmodule
`default_nettype wire

// ----- bench/bicubic_bezier_surface_eval_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bicubic_bezier_surface_eval_tb
// Self-checking bench for the bicubic Bezier surface evaluator. It fills
// the control point grid, then runs directed and random point writes and
// surface evaluations under several grid settings. A built-in fixed point
// predictor gives the expected surface point of every evaluation, and each
// done strobe is checked against the oldest pending point.
// ----------------------------------------------------------------------------
module bicubic_bezier_surface_eval_tb;

    localparam int GRID_SLOTS = 625;   // 25 x 25 points covers every setting
    localparam int DRAIN_WAIT = 40;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } surf_point_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        func;
    logic [9:0]  point_slot;
    logic [31:0] coord_x;
    logic [31:0] coord_y;
    logic [31:0] coord_z;
    logic [16:0] param_u;
    logic [16:0] param_v;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [3:0]  cfg_data;
    logic        done;
    logic [31:0] surf_x;
    logic [31:0] surf_y;
    logic [31:0] surf_z;

    // predictor copy of the grid and settings
    logic [31:0] grid_x [0:1023];
    logic [31:0] grid_y [0:1023];
    logic [31:0] grid_z [0:1023];
    logic [3:0]  across_cnt;
    logic [3:0]  down_cnt;
    logic        across_wrap;
    logic        down_wrap;

    surf_point_t pending_points[$];
    int          error_count;
    bit          no_idle;

    bicubic_bezier_surface_eval u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .func       (func),
        .point_slot (point_slot),
        .coord_x    (coord_x),
        .coord_y    (coord_y),
        .coord_z    (coord_z),
        .param_u    (param_u),
        .param_v    (param_v),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .done       (done),
        .surf_x     (surf_x),
        .surf_y     (surf_y),
        .surf_z     (surf_z)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // run limit
    initial
    begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic longint eff_count(input logic [3:0] p);
        if (p == 4'd0)
            return 1;
        if (p > 4'd8)
            return 8;
        return longint'(p);
    endfunction

    // cubic bernstein weights by de casteljau, rounded per step
    function automatic void cubic_weights(input longint t, output longint b[4]);
        longint w;
        w = 65536 - t;
        b[0] = 65536;
        b[1] = 0;
        b[2] = 0;
        b[3] = 0;
        for (int j = 1; j <= 3; j++)
        begin
            for (int i = j; i >= 1; i--)
                b[i] = (b[i] * w + b[i-1] * t + 32768) >> 16;
            b[0] = (b[0] * w + 32768) >> 16;
        end
    endfunction

    // patch start index and local fraction on one axis
    function automatic void find_patch(input longint param, input longint p,
                                       output longint first, output longint t);
        longint s;
        longint k;
        if (param > 65536)
            param = 65536;
        s = param * p;
        k = s >> 16;
        if (k >= p)
            k = p - 1;
        first = 3 * k;
        t = s - (k << 16);
    endfunction

    function automatic longint round_q16(input longint a);
        return (a + 32768) >>> 16;
    endfunction

    function automatic logic [31:0] clamp32(input longint a);
        if (a > 64'sd2147483647)
            return 32'h7fffffff;
        if (a < -64'sd2147483648)
            return 32'h80000000;
        return a[31:0];
    endfunction

    function automatic surf_point_t surface_point(input logic [16:0] pu,
                                                  input logic [16:0] pv);
        longint nu, nv, pa, pd, col, row, tu, tv, r, c, idx;
        longint wu[4];
        longint wv[4];
        longint part[3];
        longint acc[3];
        surf_point_t res;
        pa = eff_count(across_cnt);
        pd = eff_count(down_cnt);
        nu = across_wrap ? 3 * pa : 3 * pa + 1;
        nv = down_wrap ? 3 * pd : 3 * pd + 1;
        find_patch(longint'(pu), pa, col, tu);
        find_patch(longint'(pv), pd, row, tv);
        cubic_weights(tu, wu);
        cubic_weights(tv, wv);
        acc = '{0, 0, 0};
        for (int i = 0; i < 4; i++)
        begin
            part = '{0, 0, 0};
            r = row + i;
            if (down_wrap)
                r = r % nv;
            for (int j = 0; j < 4; j++)
            begin
                c = col + j;
                if (across_wrap)
                    c = c % nu;
                idx = r * nu + c;
                if (idx < 1024)
                begin
                    part[0] += longint'(signed'(grid_x[idx])) * wu[j];
                    part[1] += longint'(signed'(grid_y[idx])) * wu[j];
                    part[2] += longint'(signed'(grid_z[idx])) * wu[j];
                end
            end
            for (int k = 0; k < 3; k++)
                acc[k] += round_q16(part[k]) * wv[i];
        end
        res.x = clamp32(round_q16(acc[0]));
        res.y = clamp32(round_q16(acc[1]));
        res.z = clamp32(round_q16(acc[2]));
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        surf_point_t want;
        if (rst_n && done)
        begin
            if (pending_points.size() == 0)
                report_mismatch("unexpected result", surf_x, 32'h0);
            else
            begin
                want = pending_points.pop_front();
                if (surf_x !== want.x)
                    report_mismatch("surf_x", surf_x, want.x);
                if (surf_y !== want.y)
                    report_mismatch("surf_y", surf_y, want.y);
                if (surf_z !== want.z)
                    report_mismatch("surf_z", surf_z, want.z);
            end
        end
    end

    // one item transfer; returns at the accepting edge with start still high
    task automatic send_item(input logic f, input logic [9:0] slot,
                             input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z, input logic [16:0] pu,
                             input logic [16:0] pv);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        func       <= f;
        point_slot <= slot;
        coord_x    <= x;
        coord_y    <= y;
        coord_z    <= z;
        param_u    <= pu;
        param_v    <= pv;
        do
            @(posedge clk);
        while (busy);
        if (f == bbse_pkg::FUNC_WRITE)
        begin
            grid_x[slot] = x;
            grid_y[slot] = y;
            grid_z[slot] = z;
        end
        else
            pending_points = {pending_points, surface_point(pu, pv)};
    endtask

    task automatic write_point(input logic [9:0] slot, input logic [31:0] x,
                               input logic [31:0] y, input logic [31:0] z);
        send_item(bbse_pkg::FUNC_WRITE, slot, x, y, z, 17'($urandom), 17'($urandom));
    endtask

    task automatic eval_point(input logic [16:0] pu, input logic [16:0] pv);
        send_item(bbse_pkg::FUNC_EVAL, 10'($urandom), $urandom, $urandom, $urandom,
                  pu, pv);
    endtask

    task automatic wait_drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_points.size() != 0)
            @(posedge clk);
    endtask

    // register write while idle
    task automatic write_reg(input logic [1:0] idx, input logic [3:0] data);
        wait_drain();
        repeat (DRAIN_WAIT) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            bbse_pkg::REG_PATCHES_ACROSS: across_cnt = data;
            bbse_pkg::REG_PATCHES_DOWN:   down_cnt = data;
            bbse_pkg::REG_WRAP_ACROSS:    across_wrap = data[0];
            default:                      down_wrap = data[0];
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_grid(input logic [3:0] pa, input logic [3:0] pd,
                            input logic [3:0] wa, input logic [3:0] wd);
        write_reg(bbse_pkg::REG_PATCHES_ACROSS, pa);
        write_reg(bbse_pkg::REG_PATCHES_DOWN, pd);
        write_reg(bbse_pkg::REG_WRAP_ACROSS, wa);
        write_reg(bbse_pkg::REG_WRAP_DOWN, wd);
    endtask

    function automatic logic [16:0] rand_param(input logic [3:0] pc);
        int p;
        p = int'(eff_count(pc));
        case ($urandom_range(0, 9))
            0:       return 17'd0;
            1:       return 17'd65536;
            2:       return 17'($urandom_range(65537, 131071));
            3:       return 17'(($urandom_range(0, p) * 65536) / p);
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    // every grid slot gets written so no read hits an unwritten entry
    task automatic test_fill_grid();
        no_idle = 1'b1;
        for (int s = 0; s < GRID_SLOTS; s++)
            write_point(10'(s), $urandom, $urandom, $urandom);
        no_idle = 1'b0;
    endtask

    task automatic test_directed();
        // coordinate extremes, last slot
        write_point(10'd0, 32'h7fffffff, 32'h80000000, 32'h00000000);
        write_point(10'd1, 32'h7fffffff, 32'h80000000, 32'hffffffff);
        write_point(10'd1023, 32'h80000000, 32'h7fffffff, 32'h00010000);
        eval_point(17'd0, 17'd0);
        eval_point(17'd65536, 17'd65536);
        eval_point(17'h1ffff, 17'h1ffff);
        eval_point(17'd32768, 17'd0);
        // widest open grid, counts past the limit and zero
        set_grid(4'd8, 4'd8, 4'd0, 4'd0);
        eval_point(17'd65536, 17'd65536);
        eval_point(17'd8192, 17'd57344);
        set_grid(4'd15, 4'd0, 4'd1, 4'd1);
        eval_point(17'd65536, 17'd0);
        eval_point(17'd65535, 17'd65536);
        // wrapped at both extremes of the patch count, then wrap only down
        set_grid(4'd1, 4'd8, 4'd1, 4'd1);
        eval_point(17'd65536, 17'd65536);
        eval_point(17'd1, 17'd65535);
        set_grid(4'd9, 4'd2, 4'd14, 4'd3);
        eval_point(17'd65536, 17'd32768);
        eval_point(17'd40000, 17'h10001);
    endtask

    task automatic test_random(input int count);
        logic [3:0] pa, pd;
        for (int ph = 0; ph < 8; ph++)
        begin
            pa = 4'($urandom);
            pd = 4'($urandom);
            set_grid(pa, pd, 4'($urandom), 4'($urandom));
            no_idle = (ph % 3 == 2);
            for (int n = 0; n < count / 8; n++)
            begin
                if ($urandom_range(0, 9) < 3)
                    write_point(10'($urandom), $urandom, $urandom, $urandom);
                else
                    eval_point(rand_param(pa), rand_param(pd));
                // sender holds off until the evaluator has emptied
                if (n == count / 16)
                    wait_drain();
            end
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        func        = bbse_pkg::FUNC_WRITE;
        point_slot  = '0;
        coord_x     = '0;
        coord_y     = '0;
        coord_z     = '0;
        param_u     = '0;
        param_v     = '0;
        cfg_valid   = 1'b0;
        cfg_index   = bbse_pkg::REG_PATCHES_ACROSS;
        cfg_data    = '0;
        across_cnt  = 4'd1;
        down_cnt    = 4'd1;
        across_wrap = 1'b0;
        down_wrap   = 1'b0;
        error_count = 0;
        no_idle     = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_fill_grid();
        test_directed();
        test_random(560);

        wait_drain();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/bbse_pkg.sv
rtl/bbse_weights.sv
rtl/bicubic_bezier_surface_eval.sv
bench/bicubic_bezier_surface_eval_tb.sv
